@@ rtl/plm_pkg.sv @@
// Shared constants, arctangent table and state type for the polyline segment block.
package plm_pkg;

	localparam int HEADING_W   = 25;
	localparam int LENGTH_W    = 33;
	localparam int VEC_W       = 63;
	localparam int ANG_W       = 34;
	localparam int GUARD_TOP   = 60;
	localparam int STAGE_CNT_W = 6;
	localparam int TAB_W       = 30;
	localparam int QUEUE_DEPTH = 2;

	localparam logic signed [ANG_W-1:0]     QUARTER_TURN = 34'sd1509949440;
	localparam logic signed [ANG_W-1:0]     ROUND_HALF   = 34'sd128;
	localparam logic signed [HEADING_W-1:0] HEADING_MAX  = 25'sd11796480;

	localparam logic [TAB_W-1:0] ATAN_TAB [32] = '{
		30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
		30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
		30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
		30'd234684,    30'd117342,    30'd58671,     30'd29335,
		30'd14668,     30'd7334,      30'd3667,      30'd1833,
		30'd917,       30'd458,       30'd229,       30'd115,
		30'd57,        30'd29,        30'd14,        30'd7,
		30'd4,         30'd2,         30'd1,         30'd0
	};

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SQ_X,
		BK_SQ_Y,
		BK_ROOT,
		BK_DONE
	} back_state_t;

endpackage

@@ rtl/plm_if.sv @@
// Vertex and segment channel interfaces.
interface plm_vtx_if #(
	parameter int COORD_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic                          starts_polyline;

	modport source (
		output valid,
		output point_x,
		output point_y,
		output starts_polyline,
		input  ready
	);

	modport sink (
		input  valid,
		input  point_x,
		input  point_y,
		input  starts_polyline,
		output ready
	);
endinterface

interface plm_seg_if;
	import plm_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [HEADING_W-1:0] heading;
	logic [LENGTH_W-1:0]         seg_length;

	modport source (
		output valid,
		output heading,
		output seg_length,
		input  ready
	);

	modport sink (
		input  valid,
		input  heading,
		input  seg_length,
		output ready
	);
endinterface

@@ rtl/plm_front.sv @@
// Front end: vertex intake, previous vertex store and segment classification.
module plm_front #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	plm_vtx_if.sink                     vtx,
	input  logic                        q_full,
	output logic                        q_push,
	output logic signed [COORD_WIDTH:0] dx,
	output logic signed [COORD_WIDTH:0] dy,
	output logic                        zero_len
);
	logic signed [COORD_WIDTH-1:0] prev_x_q;
	logic signed [COORD_WIDTH-1:0] prev_y_q;
	logic                          have_prev_q;
	logic                          accept;

	assign vtx.ready = !q_full;
	assign accept    = vtx.valid && vtx.ready;
	assign q_push    = accept && !vtx.starts_polyline && have_prev_q;

	assign dx = {vtx.point_x[COORD_WIDTH-1], vtx.point_x} - {prev_x_q[COORD_WIDTH-1], prev_x_q};
	assign dy = {vtx.point_y[COORD_WIDTH-1], vtx.point_y} - {prev_y_q[COORD_WIDTH-1], prev_y_q};
	assign zero_len = (vtx.point_x == prev_x_q) && (vtx.point_y == prev_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
		end else if (accept) begin
			have_prev_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_x_q <= vtx.point_x;
			prev_y_q <= vtx.point_y;
		end
	end
endmodule

@@ rtl/plm_queue.sv @@
// Short segment queue between front and back end.
module plm_queue #(
	parameter int DATA_W = 67
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output logic [DATA_W-1:0] head_data
);
	import plm_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_W-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  count_q;

	assign full       = count_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end
endmodule

@@ rtl/plm_back.sv @@
// Back end: iterative CORDIC heading, shift-add squarer and bit-serial square root.
module plm_back #(
	parameter int COORD_WIDTH   = 32,
	parameter int CORDIC_STAGES = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  logic signed [COORD_WIDTH:0] head_dx,
	input  logic signed [COORD_WIDTH:0] head_dy,
	input  logic                        head_zero,
	output logic                        pop,
	plm_seg_if.source                   seg
);
	import plm_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int SW    = 2 * CW + 2;
	localparam int RW    = CW + 4;
	localparam int RTW   = CW + 1;
	localparam int CNT_W = $clog2(CW + 1);
	localparam int GUARD = GUARD_TOP - CW;
	localparam int LXW   = (RTW > LENGTH_W) ? RTW : LENGTH_W;

	back_state_t state_q;
	back_state_t state_d;

	logic [CNT_W-1:0] cnt_q;
	logic [SW-1:0]    md_q;
	logic [CW-1:0]    mr_q;
	logic [CW-1:0]    ay_q;
	logic [SW-1:0]    acc_q;
	logic [RW-1:0]    rem_q;
	logic [RTW-1:0]   root_q;
	logic             zero_q;

	logic signed [VEC_W-1:0] cx_q;
	logic signed [VEC_W-1:0] cy_q;
	logic signed [ANG_W-1:0] z_q;
	logic [STAGE_CNT_W-1:0]  c_cnt_q;

	logic                        valid_q;
	logic signed [HEADING_W-1:0] heading_q;
	logic [LENGTH_W-1:0]         len_q;

	logic sq_step;
	logic sq_swap;
	logic root_init;
	logic root_step;
	logic out_load;
	logic sq_last;
	logic root_last;
	logic c_done;
	logic out_free;

	logic signed [CW:0]      ndx;
	logic signed [CW:0]      ndy;
	logic [CW-1:0]           ax;
	logic [CW-1:0]           ay;
	logic signed [VEC_W-1:0] dxe;
	logic signed [VEC_W-1:0] dye;
	logic signed [VEC_W-1:0] cx0;
	logic signed [VEC_W-1:0] cy0;
	logic signed [VEC_W-1:0] cx_init;
	logic signed [VEC_W-1:0] cy_init;
	logic signed [ANG_W-1:0] z_init;

	logic [4:0]              idx;
	logic signed [VEC_W-1:0] sx;
	logic signed [VEC_W-1:0] sy;
	logic signed [ANG_W-1:0] at;

	logic [RW-1:0] remn;
	logic [RW-1:0] trial;
	logic          take;

	logic signed [ANG_W-1:0] zr;
	logic signed [ANG_W-9:0] hs;
	logic signed [ANG_W-9:0] hc;
	logic [LXW-1:0]          root_ext;

	assign sq_last   = cnt_q == CNT_W'(CW - 1);
	assign root_last = cnt_q == CNT_W'(CW);
	assign c_done    = c_cnt_q == STAGE_CNT_W'(CORDIC_STAGES);
	assign out_free  = !valid_q || seg.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (head_valid) begin
					state_d = BK_SQ_X;
				end
			end
			BK_SQ_X: begin
				if (sq_last) begin
					state_d = BK_SQ_Y;
				end
			end
			BK_SQ_Y: begin
				if (sq_last) begin
					state_d = BK_ROOT;
				end
			end
			BK_ROOT: begin
				if (root_last) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (c_done && out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		sq_step   = 1'b0;
		sq_swap   = 1'b0;
		root_init = 1'b0;
		root_step = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				pop = head_valid;
			end
			BK_SQ_X: begin
				sq_step = 1'b1;
				sq_swap = sq_last;
			end
			BK_SQ_Y: begin
				sq_step   = 1'b1;
				root_init = sq_last;
			end
			BK_ROOT: begin
				root_step = 1'b1;
			end
			BK_DONE: begin
				out_load = c_done && out_free;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cnt_q   <= '0;
			c_cnt_q <= STAGE_CNT_W'(CORDIC_STAGES);
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				cnt_q <= '0;
			end else if (sq_step) begin
				cnt_q <= sq_last ? '0 : cnt_q + 1'b1;
			end else if (root_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (pop) begin
				c_cnt_q <= '0;
			end else if (!c_done) begin
				c_cnt_q <= c_cnt_q + 1'b1;
			end
			if (out_load) begin
				valid_q <= 1'b1;
			end else if (seg.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// magnitudes and quadrant fold of the incoming segment
	assign ndx = -head_dx;
	assign ndy = -head_dy;
	assign ax  = head_dx[CW] ? ndx[CW-1:0] : head_dx[CW-1:0];
	assign ay  = head_dy[CW] ? ndy[CW-1:0] : head_dy[CW-1:0];
	assign dxe = VEC_W'(head_dx);
	assign dye = VEC_W'(head_dy);
	assign cx0 = (-dye) <<< GUARD;
	assign cy0 = dxe <<< GUARD;

	always_comb begin
		cx_init = cx0;
		cy_init = cy0;
		z_init  = '0;
		if (cx0[VEC_W-1]) begin
			if (!cy0[VEC_W-1]) begin
				cx_init = cy0;
				cy_init = -cx0;
				z_init  = QUARTER_TURN;
			end else begin
				cx_init = -cy0;
				cy_init = cx0;
				z_init  = -QUARTER_TURN;
			end
		end
	end

	assign idx = c_cnt_q[4:0];
	assign sx  = cx_q >>> idx;
	assign sy  = cy_q >>> idx;
	assign at  = ANG_W'(ATAN_TAB[idx]);

	always_ff @(posedge clk) begin
		if (pop) begin
			cx_q <= cx_init;
			cy_q <= cy_init;
			z_q  <= z_init;
		end else if (!c_done) begin
			if (cy_q[VEC_W-1]) begin
				cx_q <= cx_q - sy;
				cy_q <= cy_q + sx;
				z_q  <= z_q - at;
			end else begin
				cx_q <= cx_q + sy;
				cy_q <= cy_q - sx;
				z_q  <= z_q + at;
			end
		end
	end

	assign remn  = {rem_q[RW-3:0], acc_q[SW-1:SW-2]};
	assign trial = RW'({root_q, 2'b01});
	assign take  = remn >= trial;

	always_ff @(posedge clk) begin
		if (pop) begin
			md_q   <= SW'(ax);
			mr_q   <= ax;
			ay_q   <= ay;
			acc_q  <= '0;
			zero_q <= head_zero;
		end else if (sq_step) begin
			acc_q <= acc_q + (mr_q[0] ? md_q : '0);
			if (sq_swap) begin
				md_q <= SW'(ay_q);
				mr_q <= ay_q;
			end else begin
				md_q <= md_q << 1;
				mr_q <= mr_q >> 1;
			end
			if (root_init) begin
				rem_q  <= '0;
				root_q <= '0;
			end
		end else if (root_step) begin
			acc_q  <= acc_q << 2;
			rem_q  <= take ? remn - trial : remn;
			root_q <= {root_q[RTW-2:0], take};
		end
	end

	// round, shift to 1/65536 degree and clamp to a half turn
	assign zr = z_q + ROUND_HALF;
	assign hs = zr[ANG_W-1:8];

	always_comb begin
		if (hs > HEADING_MAX) begin
			hc = HEADING_MAX;
		end else if (hs < -HEADING_MAX) begin
			hc = -HEADING_MAX;
		end else begin
			hc = hs;
		end
	end

	assign root_ext = LXW'(root_q);

	always_ff @(posedge clk) begin
		if (out_load) begin
			heading_q <= zero_q ? '0 : hc[HEADING_W-1:0];
			len_q     <= root_ext[LENGTH_W-1:0];
		end
	end

	assign seg.valid      = valid_q;
	assign seg.heading    = heading_q;
	assign seg.seg_length = len_q;
endmodule

@@ rtl/polyline_segment_heading_length.sv @@
// Top level of the polyline segment heading and length block.
//
//   channel  dir  transaction                                   handshake
//   vtx      in   point_x, point_y, starts_polyline             valid/ready
//   seg      out  heading, seg_length                           valid/ready
//
// In the back end a segment passes through the one-bit-per-cycle shift-add squarer and
// square root; the CORDIC runs alongside.
// Vertices that start a polyline are taken one per cycle while the two-entry queue has room.
// arst_n clears control state at once; the stored vertex is written before it is read.
// A full queue drops vtx.ready; a stalled result holds in the output register while the
// back end carries on with the next queued segment.
module polyline_segment_heading_length #(
	parameter int COORD_WIDTH   = 32,
	parameter int CORDIC_STAGES = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	plm_vtx_if.sink   vtx,
	plm_seg_if.source seg
);
	import plm_pkg::*;

	localparam int DW    = COORD_WIDTH + 1;
	localparam int QDATA = 2 * DW + 1;

	logic                 q_push;
	logic                 q_full;
	logic                 q_pop;
	logic                 q_valid;
	logic [QDATA-1:0]     q_head;
	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic                 zero_len;
	logic signed [DW-1:0] head_dx;
	logic signed [DW-1:0] head_dy;
	logic                 head_zero;

	plm_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.vtx     (vtx),
		.q_full  (q_full),
		.q_push  (q_push),
		.dx      (dx),
		.dy      (dy),
		.zero_len(zero_len)
	);

	plm_queue #(
		.DATA_W(QDATA)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({dx, dy, zero_len}),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head_data (q_head)
	);

	assign head_dx   = q_head[QDATA-1:DW+1];
	assign head_dy   = q_head[DW:1];
	assign head_zero = q_head[0];

	plm_back #(
		.COORD_WIDTH  (COORD_WIDTH),
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(q_valid),
		.head_dx   (head_dx),
		.head_dy   (head_dy),
		.head_zero (head_zero),
		.pop       (q_pop),
		.seg       (seg)
	);
endmodule

@@ rtl/plm_checker.sv @@
// Port-level checks on the segment result channel, bound to the top level.
module plm_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 valid,
	input logic                                 ready,
	input logic signed [plm_pkg::HEADING_W-1:0] heading,
	input logic [plm_pkg::LENGTH_W-1:0]         seg_length
);
	import plm_pkg::*;

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("segment transaction dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> $stable(heading) && $stable(seg_length))
		else $error("segment payload changed while stalled");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (heading <= HEADING_MAX) && (heading >= -HEADING_MAX))
		else $error("heading beyond a half turn");

	a_zero_segment: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (seg_length == '0) |-> heading == '0)
		else $error("zero-length segment with nonzero heading");
endmodule

bind polyline_segment_heading_length plm_checker u_plm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.valid     (seg.valid),
	.ready     (seg.ready),
	.heading   (seg.heading),
	.seg_length(seg.seg_length)
);

@@ sim/tb_polyline_segment_heading_length.sv @@
// Testbench for the polyline segment block: a directed vertex table, then random polylines.
module tb_polyline_segment_heading_length;
	import plm_pkg::*;

	localparam int  COORD_W      = 32;
	localparam int  STAGES       = 24;
	localparam int  SEG_CYCLES   = 3 * COORD_W + 3;
	localparam int  RANDOM_ITEMS = 1625;
	localparam int  CYCLE_LIMIT  = 1000000;
	localparam int  C_MIN        = 32'sh8000_0000;
	localparam int  C_MAX        = 32'sh7fff_ffff;

	localparam longint QUARTER_DEG24 = 64'sd1509949440;
	localparam longint HEADING_LIM   = 64'sd11796480;
	localparam longint ATAN_DEG24 [32] = '{
		754974720, 445687602, 235489088, 119537938,
		60000934,  30029717,  15018523,  7509720,
		3754917,   1877466,   938734,    469367,
		234684,    117342,    58671,     29335,
		14668,     7334,      3667,      1833,
		917,       458,       229,       115,
		57,        29,        14,        7,
		4,         2,         1,         0
	};

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_SILENT,
		ROW_ZERO
	} row_kind_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               start;
		row_kind_t          kind;
	} vertex_row_t;

	typedef struct packed {
		logic signed [HEADING_W-1:0] heading;
		logic [LENGTH_W-1:0]         seg_length;
	} segment_t;

	localparam int DIR_ROWS = 24;
	localparam vertex_row_t DIRECTED [DIR_ROWS] = '{
		'{32'sd0,      32'sd0,      1'b0, ROW_SILENT},
		'{32'sd0,      32'sd0,      1'b0, ROW_ZERO},
		'{32'sd256,    32'sd0,      1'b0, ROW_PREDICT},
		'{32'sd256,    -32'sd256,   1'b0, ROW_PREDICT},
		'{32'sd0,      -32'sd256,   1'b0, ROW_PREDICT},
		'{32'sd0,      32'sd0,      1'b0, ROW_PREDICT},
		'{C_MAX,       C_MAX,       1'b1, ROW_SILENT},
		'{C_MIN,       C_MIN,       1'b0, ROW_PREDICT},
		'{C_MAX,       C_MIN,       1'b0, ROW_PREDICT},
		'{C_MIN,       C_MAX,       1'b0, ROW_PREDICT},
		'{C_MIN,       C_MAX,       1'b0, ROW_ZERO},
		'{C_MIN,       C_MAX,       1'b1, ROW_SILENT},
		'{C_MIN,       C_MAX,       1'b1, ROW_SILENT},
		'{C_MIN + 1,   C_MAX,       1'b0, ROW_PREDICT},
		'{C_MIN + 1,   C_MAX - 1,   1'b0, ROW_PREDICT},
		'{-32'sd1,     -32'sd1,     1'b1, ROW_SILENT},
		'{32'sd0,      32'sd0,      1'b0, ROW_PREDICT},
		'{32'sd1,      -32'sd1,     1'b0, ROW_PREDICT},
		'{32'sd0,      32'sd0,      1'b0, ROW_PREDICT},
		'{-32'sd1,     -32'sd1,     1'b0, ROW_PREDICT},
		'{32'sd0,      32'sd0,      1'b1, ROW_SILENT},
		'{-32'sd1,     32'sd1000000, 1'b0, ROW_PREDICT},
		'{32'sd0,      32'sd0,      1'b1, ROW_SILENT},
		'{32'sd1,      32'sd1000000, 1'b0, ROW_PREDICT}
	};

	logic clk = 1'b0;
	logic arst_n;

	plm_vtx_if #(.COORD_WIDTH(COORD_W)) vtx_ch ();
	plm_seg_if                           seg_ch ();

	polyline_segment_heading_length #(
		.COORD_WIDTH   (COORD_W),
		.CORDIC_STAGES (STAGES)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vtx    (vtx_ch),
		.seg    (seg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic signed [31:0] held_x;
	logic signed [31:0] held_y;
	bit                 held_valid;
	segment_t           pending_segments [$];
	bit                 calm;
	int                 mismatches;
	int                 cycles;
	int                 stall_left;

	// track the previous vertex and work out the segment it closes, if any
	function automatic bit predict_segment(input logic signed [31:0] x, input logic signed [31:0] y,
			input bit start, output segment_t seg_out);
		longint     dx;
		longint     dy;
		longint     vx;
		longint     vy;
		longint     t;
		longint     z;
		longint     sx;
		longint     sy;
		longint     h;
		logic [63:0]  ax;
		logic [63:0]  ay;
		logic [127:0] sq;
		logic [63:0]  root;
		logic [63:0]  trial;
		seg_out = '0;
		if (start || !held_valid) begin
			held_x     = x;
			held_y     = y;
			held_valid = 1'b1;
			return 1'b0;
		end
		dx = longint'(x) - longint'(held_x);
		dy = longint'(y) - longint'(held_y);
		held_x = x;
		held_y = y;
		if (dx == 0 && dy == 0)
			return 1'b1;
		vx = (-dy) <<< (60 - COORD_W);
		vy = dx <<< (60 - COORD_W);
		z  = 0;
		if (vx < 0) begin
			t = vx;
			if (vy >= 0) begin
				vx = vy;
				vy = -t;
				z  = QUARTER_DEG24;
			end else begin
				vx = -vy;
				vy = t;
				z  = -QUARTER_DEG24;
			end
		end
		for (int i = 0; i < STAGES; i++) begin
			sx = vx >>> i;
			sy = vy >>> i;
			if (vy < 0) begin
				vx = vx - sy;
				vy = vy + sx;
				z  = z - ATAN_DEG24[i];
			end else begin
				vx = vx + sy;
				vy = vy - sx;
				z  = z + ATAN_DEG24[i];
			end
		end
		h = (z + 128) >>> 8;
		if (h > HEADING_LIM)
			h = HEADING_LIM;
		else if (h < -HEADING_LIM)
			h = -HEADING_LIM;
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
		root = '0;
		for (int b = 40; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (128'(trial) * 128'(trial) <= sq)
				root = trial;
		end
		seg_out.heading    = h[HEADING_W-1:0];
		seg_out.seg_length = root[LENGTH_W-1:0];
		return 1'b1;
	endfunction

	task automatic send_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
			input bit start, input row_kind_t kind);
		int       gap;
		bit       has_seg;
		segment_t seg_exp;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			vtx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vtx_ch.valid           <= 1'b1;
		vtx_ch.point_x         <= x;
		vtx_ch.point_y         <= y;
		vtx_ch.starts_polyline <= start;
		@(posedge clk);
		while (!vtx_ch.ready)
			@(posedge clk);
		has_seg = predict_segment(x, y, start, seg_exp);
		case (kind)
			ROW_PREDICT: begin
				if (has_seg)
					pending_segments.insert(pending_segments.size(), seg_exp);
			end
			ROW_ZERO: begin
				seg_exp = '0;
				pending_segments.insert(pending_segments.size(), seg_exp);
			end
			default: begin
			end
		endcase
	endtask

	// result side: random back-pressure, compare against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		segment_t exp_seg;
		int       wait_draw;
		if (!arst_n) begin
			seg_ch.ready <= 1'b0;
			stall_left   <= 0;
		end else if (seg_ch.valid && seg_ch.ready) begin
			if (pending_segments.size() == 0) begin
				$display("%0t: unexpected segment heading %0d length %0d", $time,
					seg_ch.heading, seg_ch.seg_length);
				mismatches++;
			end else begin
				exp_seg = pending_segments.pop_front();
				if (seg_ch.heading !== exp_seg.heading) begin
					$display("%0t: heading expected %0d actual %0d", $time,
						exp_seg.heading, seg_ch.heading);
					mismatches++;
				end
				if (seg_ch.seg_length !== exp_seg.seg_length) begin
					$display("%0t: seg_length expected %0d actual %0d", $time,
						exp_seg.seg_length, seg_ch.seg_length);
					mismatches++;
				end
			end
			wait_draw    = calm ? 0 : $urandom_range(0, 3);
			stall_left   <= wait_draw;
			seg_ch.ready <= (wait_draw == 0);
		end else if (!seg_ch.ready) begin
			if (stall_left <= 1)
				seg_ch.ready <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			seg_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("polyline_segment_heading_length regression: fail");
			$finish;
		end
	end

	initial begin
		logic signed [31:0] cur_x;
		logic signed [31:0] cur_y;
		logic signed [31:0] delta;
		int                 run_left;
		bit                 start;
		arst_n                 = 1'b0;
		vtx_ch.valid           = 1'b0;
		vtx_ch.point_x         = '0;
		vtx_ch.point_y         = '0;
		vtx_ch.starts_polyline = 1'b0;
		held_x                 = '0;
		held_y                 = '0;
		held_valid             = 1'b0;
		calm                   = 1'b0;
		run_left               = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++)
			send_vertex(DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].start, DIRECTED[r].kind);

		cur_x = 0;
		cur_y = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				calm = ($urandom_range(0, 3) == 0);
			// hold off until the block has drained
			if (n == RANDOM_ITEMS / 2) begin
				vtx_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending_segments.size() != 0)
					@(posedge clk);
			end
			if (run_left == 0) begin
				start    = 1'b1;
				run_left = $urandom_range(1, 12);
			end else begin
				start = ($urandom_range(0, 19) == 0);
				run_left--;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					delta = $signed($urandom) >>> $urandom_range(0, 31);
					cur_x = cur_x + delta;
					delta = $signed($urandom) >>> $urandom_range(0, 31);
					cur_y = cur_y + delta;
				end
				5, 6: begin
					cur_x = $urandom;
					cur_y = $urandom;
				end
				7: begin
					case ($urandom_range(0, 3))
						0: cur_x = C_MIN;
						1: cur_x = C_MAX;
						2: cur_x = 0;
						default: cur_x = -1;
					endcase
					case ($urandom_range(0, 3))
						0: cur_y = C_MIN;
						1: cur_y = C_MAX;
						2: cur_y = 0;
						default: cur_y = -1;
					endcase
				end
				8: begin
				end
				default: begin
					delta = $signed($urandom) >>> $urandom_range(0, 31);
					if ($urandom_range(0, 1))
						cur_x = cur_x + delta;
					else
						cur_y = cur_y + delta;
				end
			endcase
			send_vertex(cur_x, cur_y, start, ROW_PREDICT);
		end
		vtx_ch.valid <= 1'b0;

		while (pending_segments.size() != 0)
			@(posedge clk);
		repeat (SEG_CYCLES + 20) @(posedge clk);
		if (mismatches == 0)
			$display("polyline_segment_heading_length regression: pass");
		else
			$display("polyline_segment_heading_length regression: fail");
		$finish;
	end

endmodule
